### hdl/msb_first_bit_packer_top_macros.svh
// ----------------------------------------------------------------------------
// MSB-first bit packer assertion macros
// Shared assertion wrappers for the packer checker.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define BPK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define BPK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/bpk_pkg.sv
// ----------------------------------------------------------------------------
// Bit packer package
// Widths, op codes and the structs passed between the packer modules.
// ----------------------------------------------------------------------------
package bpk_pkg;

  localparam int unsigned MaxFieldBits = 16;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned LenW         = 5;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned PartW        = 7;
  localparam int unsigned PendW        = 3;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned AccW         = PartW + ValueBits;
  localparam int unsigned LenLimit     = (MaxFieldBits < ValueBits) ? MaxFieldBits : ValueBits;
  localparam int unsigned SumW         = $clog2(PartW + LenLimit + 1);
  localparam int unsigned CntW         = 2;

  typedef enum logic {
    OpPut   = 1'b0,
    OpFlush = 1'b1
  } bpk_op_e;

  // One input item as held in the input register
  typedef struct packed {
    bpk_op_e              op;
    logic [ValueBits-1:0] value;
    logic [LenW-1:0]      len;
  } bpk_item_t;

  // Bytes produced by one item; a single byte travels in last_data
  typedef struct packed {
    logic [CntW-1:0]   cnt;
    logic [ByteW-1:0]  first_data;
    logic [ByteW-1:0]  last_data;
    logic [TotalW-1:0] total;
  } bpk_res_t;

endpackage

### hdl/msb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Packs variable-length fields into bytes, first bit in bit 7, with flush.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op_i, field_value_i, field_len_i
//   out      output     out_valid_o / out_ready_i out_byte_o, last_of_run_o,
//                                                 bit_total_o
//
// An item waits in the input register, where it is packed, and moves into the
// result buffer when the buffer has room; its first byte is then offered.
// The buffer sends one byte a cycle while out_ready_i is high. An item makes
// no byte, one or two; the next item enters the buffer as the last byte of
// the previous one leaves.
// Reset clears the packing state and both valid flags at once.
// A stall on the output holds the buffer, then the input register.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [bpk_pkg::ValueBits-1:0] field_value_i,
  input  logic [bpk_pkg::LenW-1:0]      field_len_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpk_pkg::ByteW-1:0]     out_byte_o,
  output logic                          last_of_run_o,
  output logic [bpk_pkg::TotalW-1:0]    bit_total_o
);
  import bpk_pkg::*;

  bpk_item_t item;
  bpk_res_t  res;
  logic      item_valid;
  logic      load_ok;
  logic      advance;

  // Move the held item into the buffer when it has room
  assign advance = item_valid && load_ok;

  bpk_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .field_value_i(field_value_i),
    .field_len_i  (field_len_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bpk_pack u_pack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item),
    .fire_i(advance),
    .res_o (res)
  );

  bpk_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .load_i       (advance),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o),
    .bit_total_o  (bit_total_o)
  );

endmodule

### hdl/bpk_in_reg.sv
// ----------------------------------------------------------------------------
// Bit packer input register
// Holds one accepted item until the packing stage takes it.
// ----------------------------------------------------------------------------
module bpk_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [bpk_pkg::ValueBits-1:0] field_value_i,
  input  logic [bpk_pkg::LenW-1:0]     field_len_i,
  input  logic                         advance_i,
  output logic                         item_valid_o,
  output bpk_pkg::bpk_item_t           item_o
);
  import bpk_pkg::*;

  logic      valid_q, valid_d;
  bpk_item_t item_q;
  logic      take;

  // Accept while empty or while the held item moves on
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.op    <= bpk_op_e'(op_i);
      item_q.value <= field_value_i;
      item_q.len   <= field_len_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hdl/bpk_pack.sv
// ----------------------------------------------------------------------------
// Bit packer core
// Merges an item's bits with the pending bits, cuts whole bytes and keeps
// the running bit count; a flush pads out the partial byte and clears the state.
// ----------------------------------------------------------------------------
module bpk_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpk_pkg::bpk_item_t item_i,
  input  logic               fire_i,
  output bpk_pkg::bpk_res_t  res_o
);
  import bpk_pkg::*;

  logic [PartW-1:0]       partial_q, partial_d;
  logic [PendW-1:0]       pending_q, pending_d;
  logic [TotalW-1:0]      written_q, written_d;
  logic                   any_q, any_d;

  logic [LenW-1:0]        len_sat;
  logic [ValueBits:0]     len_onehot;
  logic [ValueBits:0]     len_mask;
  logic [ValueBits-1:0]   new_bits;
  logic [AccW-1:0]        acc;
  logic [SumW-1:0]        sum;
  logic [SumW-1:0]        sh_hi;
  logic [SumW-1:0]        sh_lo;
  logic [ByteW-1:0]       hi_data;
  logic [ByteW-1:0]       lo_data;
  logic [PendW-1:0]       pend_new;
  logic [ByteW-1:0]       part_mask;
  logic [ByteW+PartW-1:0] flush_wide;
  logic [ByteW-1:0]       flush_data;

  // Clamp the length and mask off unused value bits
  always_comb begin
    if (item_i.len > LenW'(LenLimit)) begin
      len_sat = LenW'(LenLimit);
    end else begin
      len_sat = item_i.len;
    end
    len_onehot = (ValueBits + 1)'(1) << len_sat;
    len_mask   = len_onehot - (ValueBits + 1)'(1);
    new_bits   = item_i.value & len_mask[ValueBits-1:0];
  end

  // Append new bits below the pending ones and cut up to two bytes
  always_comb begin
    acc        = (AccW'(partial_q) << len_sat) | AccW'(new_bits);
    sum        = SumW'(pending_q) + SumW'(len_sat);
    sh_hi      = sum - SumW'(ByteW);
    sh_lo      = sum - SumW'(2 * ByteW);
    hi_data    = ByteW'(acc >> sh_hi);
    lo_data    = ByteW'(acc >> sh_lo);
    pend_new   = sum[PendW-1:0];
    part_mask  = (ByteW'(1) << pend_new) - ByteW'(1);
    flush_wide = (ByteW + PartW)'(partial_q) << (4'(ByteW) - {1'b0, pending_q});
    flush_data = flush_wide[ByteW-1:0];
  end

  // Select the results and the next state
  always_comb begin
    partial_d        = partial_q;
    pending_d        = pending_q;
    written_d        = written_q;
    any_d            = any_q;
    res_o.cnt        = '0;
    res_o.first_data = hi_data;
    res_o.last_data  = hi_data;
    res_o.total      = written_q;
    if (item_i.op == OpFlush) begin
      // Pad the partial byte, or emit a zero byte if nothing was written
      if (!any_q) begin
        res_o.cnt       = CntW'(1);
        res_o.last_data = '0;
      end else begin
        res_o.last_data = flush_data;
        if (pending_q != '0) begin
          res_o.cnt = CntW'(1);
        end
      end
      partial_d = '0;
      pending_d = '0;
      written_d = '0;
      any_d     = 1'b0;
    end else if (len_sat != '0) begin
      written_d   = written_q + TotalW'(len_sat);
      res_o.total = written_d;
      any_d       = 1'b1;
      pending_d   = pend_new;
      partial_d   = acc[PartW-1:0] & part_mask[PartW-1:0];
      if (sum >= SumW'(2 * ByteW)) begin
        res_o.cnt       = CntW'(2);
        res_o.last_data = lo_data;
      end else if (sum >= SumW'(ByteW)) begin
        res_o.cnt = CntW'(1);
      end
    end
  end

  // Advance state when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pending_q <= '0;
      written_q <= '0;
      any_q     <= 1'b0;
    end else if (fire_i) begin
      partial_q <= partial_d;
      pending_q <= pending_d;
      written_q <= written_d;
      any_q     <= any_d;
    end
  end

endmodule

### hdl/bpk_out_buf.sv
// ----------------------------------------------------------------------------
// Bit packer result buffer
// Holds the bytes of one item and hands them out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module bpk_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpk_pkg::bpk_res_t             res_i,
  input  logic                          load_i,
  output logic                          load_ok_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpk_pkg::ByteW-1:0]     out_byte_o,
  output logic                          last_of_run_o,
  output logic [bpk_pkg::TotalW-1:0]    bit_total_o
);
  import bpk_pkg::*;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]  first_q;
  logic [ByteW-1:0]  last_q;
  logic [TotalW-1:0] total_q;
  logic              pop;

  assign pop       = (cnt_q != '0) && out_ready_i;
  // Room when empty or when the last byte leaves now
  assign load_ok_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = res_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the bytes and the bit count of the item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_q <= res_i.first_data;
      last_q  <= res_i.last_data;
      total_q <= res_i.total;
    end
  end

  assign out_valid_o   = cnt_q != '0;
  assign out_byte_o    = (cnt_q == CntW'(2)) ? first_q : last_q;
  assign last_of_run_o = cnt_q == CntW'(1);
  assign bit_total_o   = total_q;

endmodule

### hdl/bpk_chk.sv
// ----------------------------------------------------------------------------
// Bit packer port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_top_macros.svh"

module bpk_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bpk_pkg::ByteW-1:0]     out_byte_o,
  input logic                          last_of_run_o,
  input logic [bpk_pkg::TotalW-1:0]    bit_total_o
);
  import bpk_pkg::*;

  // Hold a stalled result
  `BPK_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `BPK_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(last_of_run_o) && $stable(bit_total_o), "stalled result changed")
  // The second byte of an item follows at once with the same bit count
  `BPK_ASSERT(a_run_follows, out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o && (bit_total_o == $past(bit_total_o)), "run broken or count changed")
  // Input backpressure only comes from a waiting result
  `BPK_ASSERT_ALWAYS(a_ready_cause, rst_ni && !in_ready_o |-> out_valid_o, "input stalled with empty output")

endmodule

bind msb_first_bit_packer_top bpk_chk u_bpk_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .last_of_run_o(last_of_run_o),
  .bit_total_o  (bit_total_o)
);

### sim/msb_first_bit_packer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MSB-first bit packer testbench
// Sends directed and random put and flush items through the packer. Each
// accepted item is run through a local bit-packing predictor, and every
// byte that leaves the block is compared field by field with the oldest
// predicted byte. Both handshakes idle in random bursts, with one long
// output stall and two input pauses until the output has drained.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top_test;
  import bpk_pkg::*;

  // One byte as it should leave the packer
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic              last;
    logic [TotalW-1:0] total;
  } packed_byte_t;

  // One item waiting to be offered; drain_first pauses until nothing is due
  typedef struct {
    bpk_op_e              op;
    logic [ValueBits-1:0] value;
    logic [LenW-1:0]      len;
    bit                   drain_first;
  } field_item_t;

  localparam int unsigned RandomItems  = 1100;
  localparam int unsigned QuietTail    = 150;
  localparam int unsigned HoldoffAt    = 400;
  localparam int unsigned HoldoffLen   = 80;
  localparam int unsigned DrainLimit   = 5000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic                 op_i          = 1'b0;
  logic [ValueBits-1:0] field_value_i = '0;
  logic [LenW-1:0]      field_len_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [ByteW-1:0]     out_byte_o;
  logic                 last_of_run_o;
  logic [TotalW-1:0]    bit_total_o;

  field_item_t  pending_items[$];
  packed_byte_t expected_bytes_q[$];
  int unsigned  items_accepted = 0;
  int unsigned  error_count    = 0;

  // Predictor state
  logic [PartW-1:0]  pk_partial = '0;
  logic [PendW-1:0]  pk_pending = '0;
  logic [TotalW-1:0] pk_written = '0;
  bit                pk_any     = 1'b0;

  msb_first_bit_packer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .field_value_i (field_value_i),
    .field_len_i   (field_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .bit_total_o   (bit_total_o)
  );

  // Pack one accepted item into bytes and queue the bytes it completes
  task automatic pack_item(input bpk_op_e op, input logic [ValueBits-1:0] value,
                           input logic [LenW-1:0] len);
    logic [LenW-1:0]      nbits;
    logic [AccW-1:0]      acc;
    logic [AccW-1:0]      shifted;
    logic [15:0]          pad;
    logic [ByteW-1:0]     made[2];
    int                   fill;
    int                   nb;
    packed_byte_t         rec;
    if (op == OpFlush) begin
      if (!pk_any) begin
        rec = '{data: '0, last: 1'b1, total: '0};
        expected_bytes_q.push_back(rec);
      end else if (pk_pending != 0) begin
        // pad the leftover bits with zeros below them
        pad = {9'd0, pk_partial} << (8 - pk_pending);
        rec = '{data: pad[7:0], last: 1'b1, total: pk_written};
        expected_bytes_q.push_back(rec);
      end
      pk_partial = '0;
      pk_pending = '0;
      pk_written = '0;
      pk_any     = 1'b0;
      return;
    end
    nbits = (len > LenLimit) ? LenW'(LenLimit) : len;
    if (nbits == 0) return;
    acc  = ({16'd0, pk_partial} << nbits) |
           ({7'd0, value} & ((AccW'(1) << nbits) - AccW'(1)));
    fill = pk_pending + nbits;
    nb   = 0;
    while (fill >= 8 && nb < 2) begin
      shifted  = acc >> (fill - 8);
      made[nb] = shifted[7:0];
      nb++;
      fill -= 8;
    end
    pk_written = pk_written + nbits;
    pk_any     = 1'b1;
    pk_pending = fill[PendW-1:0];
    shifted    = acc & ((AccW'(1) << pk_pending) - AccW'(1));
    pk_partial = shifted[PartW-1:0];
    for (int k = 0; k < nb; k++) begin
      rec = '{data: made[k], last: (k == nb - 1), total: pk_written};
      expected_bytes_q.push_back(rec);
    end
  endtask

  task automatic add_item(input bpk_op_e op, input logic [ValueBits-1:0] value,
                          input logic [LenW-1:0] len, input bit drain_first);
    field_item_t it;
    it = '{op: op, value: value, len: len, drain_first: drain_first};
    pending_items.push_back(it);
  endtask

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Input driver: offer queued items, idle in bursts, pause on drain marks
  int unsigned sender_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    field_item_t nxt;
    bit          fire;
    bit          quiet;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      op_i          <= 1'b0;
      field_value_i <= '0;
      field_len_i   <= '0;
    end else begin
      fire  = in_valid_i && in_ready_o;
      quiet = pending_items.size() < QuietTail;
      if (fire) begin
        pack_item(bpk_op_e'(op_i), field_value_i, field_len_i);
        items_accepted++;
        if (!quiet && $urandom_range(0, 4) == 0) sender_gap = $urandom_range(1, 4);
      end
      // hold the offered item until it is taken
      if (!(in_valid_i && !fire)) begin
        if (sender_gap > 0) begin
          sender_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain_first || expected_bytes_q.size() == 0)) begin
          nxt = pending_items.pop_front();
          in_valid_i    <= 1'b1;
          op_i          <= nxt.op;
          field_value_i <= nxt.value;
          field_len_i   <= nxt.len;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each byte, stall in bursts and once for a long stretch
  int unsigned stall_left   = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t want;
    bit           next_ready;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual data=%02h last=%0b total=%0d",
                   $time, out_byte_o, last_of_run_o, bit_total_o);
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_byte_o !== want.data) begin
            error_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte_o);
          end
          if (last_of_run_o !== want.last) begin
            error_count++;
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last, last_of_run_o);
          end
          if (bit_total_o !== want.total) begin
            error_count++;
            $display("%0t: bit_total mismatch: expected %0d, actual %0d",
                     $time, want.total, bit_total_o);
          end
        end
      end
      // start the long stall once, well into the run
      if (!holdoff_done && items_accepted >= HoldoffAt) begin
        holdoff_done = 1'b1;
        holdoff_left = HoldoffLen;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (pending_items.size() >= QuietTail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready_i <= next_ready;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned pick;
    int unsigned wait_cycles;
    bpk_op_e     op;
    logic [4:0]  len;

    // directed: extremes, saturation, and every flush case
    add_item(OpFlush, 16'h0000, 5'd0,  1'b0);  // flush with nothing written
    add_item(OpPut,   16'hFFFF, 5'd0,  1'b0);  // zero length writes nothing
    add_item(OpFlush, 16'hFFFF, 5'd31, 1'b0);  // still nothing written
    add_item(OpPut,   16'hFFFF, 5'd16, 1'b0);
    add_item(OpFlush, 16'h0000, 5'd0,  1'b0);  // flush on a byte boundary
    add_item(OpPut,   16'h0001, 5'd1,  1'b0);
    add_item(OpPut,   16'h0000, 5'd16, 1'b0);
    add_item(OpPut,   16'hFFF8, 5'd3,  1'b0);  // value bits above the length
    add_item(OpPut,   16'h1234, 5'd0,  1'b0);  // zero length with bits pending
    add_item(OpFlush, 16'h0000, 5'd0,  1'b0);  // flush a partial byte
    add_item(OpPut,   16'hA5A5, 5'd31, 1'b1);  // length above the limit
    add_item(OpPut,   16'h5A5A, 5'd17, 1'b0);
    add_item(OpPut,   16'h8000, 5'd16, 1'b0);
    add_item(OpPut,   16'h007F, 5'd7,  1'b0);
    add_item(OpPut,   16'h0000, 5'd1,  1'b0);
    add_item(OpPut,   16'h0080, 5'd8,  1'b0);
    add_item(OpPut,   16'h0003, 5'd2,  1'b0);
    add_item(OpFlush, 16'hFFFF, 5'd16, 1'b0);
    add_item(OpPut,   16'h5555, 5'd15, 1'b0);
    add_item(OpPut,   16'h0001, 5'd1,  1'b0);
    add_item(OpPut,   16'h2AAA, 5'd20, 1'b0);
    add_item(OpFlush, 16'h0000, 5'd0,  1'b0);

    // random: mostly puts of 1 to 16 bits, some flushes and odd lengths
    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 8) ? OpFlush : OpPut;
      pick = $urandom_range(0, 19);
      if (pick == 0)      len = 5'd0;
      else if (pick <= 3) len = 5'($urandom_range(17, 31));
      else                len = 5'($urandom_range(1, 16));
      add_item(op, 16'($urandom), len, (i == 700));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every item to be taken, then for the bytes still due
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    wait_cycles = 0;
    while (expected_bytes_q.size() != 0 && wait_cycles < DrainLimit) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (expected_bytes_q.size() != 0) begin
      error_count += expected_bytes_q.size();
      $display("%0t: %0d expected bytes never arrived, next expected data=%02h total=%0d",
               $time, expected_bytes_q.size(), expected_bytes_q[0].data,
               expected_bytes_q[0].total);
    end
    // let any stray bytes show up
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/bpk_pkg.sv
hdl/bpk_in_reg.sv
hdl/bpk_pack.sv
hdl/bpk_out_buf.sv
hdl/msb_first_bit_packer_top.sv
hdl/bpk_chk.sv
sim/msb_first_bit_packer_top_test.sv
